// ===== src/rlbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlbd_pkg: shared types of the run-length byte decoder
// payload structs of both channels and the decoder phase encoding
// ----------------------------------------------------------------------------
package rlbd_pkg;

	localparam int unsigned ByteW = 8;

	// one compressed byte as it arrives
	typedef struct packed {
		logic [ByteW-1:0] data_byte;
		logic             last_byte;
	} code_t;

	// one decoded run
	typedef struct packed {
		logic [ByteW-1:0] run_value;
		logic [ByteW-1:0] run_length;
		logic             block_end;
		logic             malformed;
	} run_t;

	// decoder phase, one-hot
	typedef enum logic [2:0] {
		PH_HEADER  = 3'b001,
		PH_REPEAT  = 3'b010,
		PH_LITERAL = 3'b100
	} phase_t;

endpackage

// ===== src/rlbd_code_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlbd_code_if: compressed byte channel
// valid/ready channel carrying one compressed byte per request
// ----------------------------------------------------------------------------
interface rlbd_code_if;
	logic             valid;
	logic             ready;
	rlbd_pkg::code_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== src/rlbd_run_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlbd_run_if: decoded run channel
// valid/ready channel carrying one (value, length) run per request
// ----------------------------------------------------------------------------
interface rlbd_run_if;
	logic            valid;
	logic            ready;
	rlbd_pkg::run_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== src/run_length_byte_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// run_length_byte_decoder: packbits-style run-length byte decoder
// takes one compressed byte per request and emits zero or one decoded run
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                                      notes
//  coded    in   data_byte[7:0], last_byte                    one compressed byte
//  runs     out  run_value[7:0], run_length[7:0], block_end,  zero or one per byte
//                malformed
//
// one byte per cycle sustained while the runs channel does not stall; a byte passes the
// input register, then the result register, before its run shows on runs
// the input register and the result register advance together whenever the result
// register is empty or being drained; while a finished run waits, a byte is taken
// only into an empty input register or when the run is taken in the same cycle
// header bytes produce no run unless they carry last_byte
// reset clears valid flags, phase (header expected) and the remaining count
//
module run_length_byte_decoder (
	input  logic          clk,
	input  logic          arst_n,
	rlbd_code_if.sink     coded,
	rlbd_run_if.source    runs
);

	localparam int unsigned ByteW = rlbd_pkg::ByteW;

	// input stage
	logic                 valid_s1;
	rlbd_pkg::code_t      code_s1;

	// decoder state
	rlbd_pkg::phase_t     phase_q;
	logic [ByteW-1:0]     remaining_q;

	// result register
	logic                 out_valid_q;
	rlbd_pkg::run_t       out_q;

	// next-state and result logic
	logic                 advance;
	logic                 emit;
	rlbd_pkg::run_t       res;
	rlbd_pkg::phase_t     phase_d;
	logic [ByteW-1:0]     remaining_d;
	logic [ByteW-1:0]     left;

	// both stages move when the result register can take a new value
	assign advance     = !out_valid_q || runs.ready;
	assign coded.ready = !valid_s1 || advance;

	assign left = (remaining_q != '0) ? remaining_q - ByteW'(1) : '0;

	always_comb begin
		emit        = 1'b0;
		res         = '0;
		phase_d     = phase_q;
		remaining_d = remaining_q;
		case (phase_q)
			rlbd_pkg::PH_REPEAT: begin
				// value byte of a repeat run
				emit           = 1'b1;
				res.run_value  = code_s1.data_byte;
				res.run_length = remaining_q;
				res.block_end  = code_s1.last_byte;
				phase_d        = rlbd_pkg::PH_HEADER;
				remaining_d    = '0;
			end
			rlbd_pkg::PH_LITERAL: begin
				// literal byte, malformed if the block ends with bytes still owed
				emit           = 1'b1;
				res.run_value  = code_s1.data_byte;
				res.run_length = ByteW'(1);
				res.block_end  = code_s1.last_byte;
				res.malformed  = code_s1.last_byte && (left != '0);
				remaining_d    = left;
				phase_d        = (left != '0) ? rlbd_pkg::PH_LITERAL : rlbd_pkg::PH_HEADER;
			end
			default: begin
				// header byte: sign bit selects repeat or literal stretch
				if (code_s1.data_byte[ByteW-1]) begin
					// repeat count 1 - n, wraps so 0x80 gives 129
					remaining_d = ByteW'(1) - code_s1.data_byte;
					phase_d     = rlbd_pkg::PH_REPEAT;
				end else begin
					remaining_d = code_s1.data_byte + ByteW'(1);
					phase_d     = rlbd_pkg::PH_LITERAL;
				end
				// block ending on a header is malformed
				if (code_s1.last_byte) begin
					emit          = 1'b1;
					res.block_end = 1'b1;
					res.malformed = 1'b1;
				end
			end
		endcase
		// every block end restarts on a fresh header
		if (code_s1.last_byte) begin
			phase_d     = rlbd_pkg::PH_HEADER;
			remaining_d = '0;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (coded.ready) begin
			valid_s1 <= coded.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (coded.ready && coded.valid) begin
			code_s1 <= coded.data;
		end
	end

	// decoder state, updated as each byte leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= rlbd_pkg::PH_HEADER;
			remaining_q <= '0;
		end else if (valid_s1 && advance) begin
			phase_q     <= phase_d;
			remaining_q <= remaining_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit) begin
			out_q <= res;
		end
	end

	assign runs.valid = out_valid_q;
	assign runs.data  = out_q;

	// a zero-length run is only ever the malformed marker
	a_zero_len_malformed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.run_length == '0) |-> out_q.malformed)
		else $error("zero-length run without malformed flag");

	// malformed runs always close the block
	a_malformed_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.malformed |-> out_q.block_end)
		else $error("malformed run not marked as block end");

	// after a last byte is consumed the decoder waits for a header
	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && code_s1.last_byte
		|=> (phase_q == rlbd_pkg::PH_HEADER) && (remaining_q == '0))
		else $error("decoder state not cleared after block end");

	// literal stretch never holds a zero count
	a_literal_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == rlbd_pkg::PH_LITERAL |-> remaining_q != '0)
		else $error("literal phase with zero bytes remaining");

endmodule
